@@ design/ncl1_pkg.sv @@
package ncl1_pkg;

  // fixed field widths of the stream beats
  localparam int SEL_W    = 2;
  localparam int IDX_W    = 6;
  localparam int ELEM_W   = 8;
  localparam int SUM_W    = 14;
  localparam int NEAR_W   = 2;

  // number of stored centres
  localparam int NUM_CENTERS = 4;

  // saturation ceiling of a running distance sum
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // parameter defaults
  localparam int FEATURE_LEN_DEF = 64;
  localparam int VALUE_BITS_DEF  = 8;

  // beat kind carried in tuser
  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  typedef logic [SUM_W-1:0] sum_t;

  // centre store access request
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [SEL_W-1:0] sel;
  } st_ctrl_t;

endpackage

@@ design/ncl1_center_store.sv @@
module ncl1_center_store
  import ncl1_pkg::*;
#(
  parameter int DEPTH  = FEATURE_LEN_DEF,
  parameter int DATA_W = VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  st_ctrl_t                              ctrl,
  input  logic [$clog2(DEPTH)-1:0]              addr,
  input  logic [DATA_W-1:0]                     wdata,
  output logic [NUM_CENTERS-1:0][DATA_W-1:0]    rdata
);

  // one bank per centre, all read at the same element position
  for (genvar c = 0; c < NUM_CENTERS; c++) begin : g_bank
    logic [DATA_W-1:0] mem_r [DEPTH];
    logic [DATA_W-1:0] rd_r;

    // write only the selected bank
    always_ff @(posedge clk) begin
      if (ctrl.wr_en && (ctrl.sel == SEL_W'(c))) begin
        mem_r[addr] <= wdata;
      end
    end

    // registered read, held while no read is issued
    always_ff @(posedge clk) begin
      if (ctrl.rd_en) begin
        rd_r <= mem_r[addr];
      end
    end

    assign rdata[c] = rd_r;
  end

endmodule

@@ design/nearest_center_l1_assign.sv @@
// Nearest-centre assignment by L1 distance over four stored centres.
// Input channel in_*: one beat per element. in_tuser selects the beat kind:
// a load beat writes element elem_index of centre center_sel, a classify beat
// adds |centre - value| at elem_index to four running distance sums. An
// elem_index at or above FEATURE_LEN is ignored by a load and adds nothing on
// a classify beat. in_tlast on a classify beat closes the vector.
// Result channel out_*: one beat per closed vector carrying the index of the
// smallest sum (lowest index on ties) and that distance; the sums are then
// cleared. Sums saturate at the 14-bit ceiling.
// Throughput: one beat per cycle while in_tready is high, load and classify alike; the centre store
// has one write and one read port per bank and the per-element work is a
// single add and saturate per centre.
// A closed vector passes the input/read stage, the final-sum stage and the output
// register in turn before out_tvalid rises.
// Reset clears the sums and the pipeline; the centre store is not cleared and
// must be loaded before it is used. When the receiver stalls, beats keep
// being accepted until a closed vector waits in both the final-sum stage and
// the output register and a further classify beat with in_tlast reaches the input stage.
module nearest_center_l1_assign
  import ncl1_pkg::*;
#(
  parameter int FEATURE_LEN = FEATURE_LEN_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // center_sel[1:0], elem_index[7:2], value[15:8]
  input  logic [0:0]  in_tuser,   // func[0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // nearest[1:0], best_distance[15:2]
);

  localparam int VAL_W = (VALUE_BITS < ELEM_W) ? VALUE_BITS : ELEM_W;
  localparam int AW    = $clog2(FEATURE_LEN);
  localparam int XW    = (AW > IDX_W) ? AW : IDX_W;

  // beat fields
  logic [SEL_W-1:0]  in_sel;
  logic [IDX_W-1:0]  in_idx;
  logic [ELEM_W-1:0] in_value;
  logic              in_func;
  logic              in_fire;
  logic              in_range;
  logic [XW-1:0]     idx_x;
  logic [AW-1:0]     st_addr;
  st_ctrl_t          st_ctrl;
  logic [NUM_CENTERS-1:0][VAL_W-1:0] st_rdata;

  assign in_sel   = in_tdata[1:0];
  assign in_idx   = in_tdata[7:2];
  assign in_value = in_tdata[15:8];
  assign in_func  = in_tuser[0];
  assign in_fire  = in_tvalid && in_tready;
  assign in_range = (int'(in_idx) < FEATURE_LEN);
  assign idx_x    = XW'(in_idx);
  assign st_addr  = idx_x[AW-1:0];

  // store write for loads, read for classify beats
  always_comb begin
    st_ctrl.wr_en = in_fire && (in_func == FUNC_LOAD) && in_range;
    st_ctrl.rd_en = in_fire && (in_func == FUNC_CLASSIFY) && in_range;
    st_ctrl.sel   = in_sel;
  end

  ncl1_center_store #(
    .DEPTH  (FEATURE_LEN),
    .DATA_W (VAL_W)
  ) u_store (
    .clk   (clk),
    .ctrl  (st_ctrl),
    .addr  (st_addr),
    .wdata (in_value[VAL_W-1:0]),
    .rdata (st_rdata)
  );

  // input stage
  logic             s1_v_r;
  logic             s1_cls_r;
  logic             s1_hit_r;
  logic             s1_last_r;
  logic [VAL_W-1:0] s1_val_r;
  logic             s1_prod;
  logic             s1_fire;

  // final-sum stage
  logic s2_v_r;
  sum_t s2_sum_r [NUM_CENTERS];
  logic s2_ready;
  logic s2_fire;

  // output register
  logic              out_v_r;
  logic [NEAR_W-1:0] out_near_r;
  sum_t              out_dist_r;
  logic              out_ready;

  // running sums
  sum_t sum_r   [NUM_CENTERS];
  sum_t sum_nxt [NUM_CENTERS];

  // stage handshakes
  assign out_ready = !out_v_r || out_tready;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s2_fire   = s2_v_r && out_ready;
  assign s1_prod   = s1_cls_r && s1_last_r;
  assign s1_fire   = s1_v_r && (!s1_prod || s2_ready);
  assign in_tready = !s1_v_r || !s1_prod || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cls_r  <= (in_func == FUNC_CLASSIFY);
      s1_hit_r  <= (in_func == FUNC_CLASSIFY) && in_range;
      s1_last_r <= in_tlast;
      s1_val_r  <= in_value[VAL_W-1:0];
    end
  end

  // absolute difference and saturating add per centre
  always_comb begin
    logic [VAL_W-1:0] diff;
    logic [SUM_W:0]   acc;
    for (int c = 0; c < NUM_CENTERS; c++) begin
      diff = (st_rdata[c] > s1_val_r) ? (st_rdata[c] - s1_val_r)
                                      : (s1_val_r - st_rdata[c]);
      acc  = {1'b0, sum_r[c]} + (SUM_W+1)'(diff);
      if (!s1_hit_r) begin
        sum_nxt[c] = sum_r[c];
      end else if (acc[SUM_W]) begin
        sum_nxt[c] = SUM_MAX;
      end else begin
        sum_nxt[c] = acc[SUM_W-1:0];
      end
    end
  end

  // sums update per classify beat, clear after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CENTERS; c++) begin
        sum_r[c] <= '0;
      end
    end else if (s1_fire && s1_cls_r) begin
      for (int c = 0; c < NUM_CENTERS; c++) begin
        sum_r[c] <= s1_last_r ? '0 : sum_nxt[c];
      end
    end
  end

  // final sums of a closed vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_fire && s1_prod) begin
      s2_v_r <= 1'b1;
    end else if (s2_fire) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_prod) begin
      for (int c = 0; c < NUM_CENTERS; c++) begin
        s2_sum_r[c] <= sum_nxt[c];
      end
    end
  end

  // minimum over the four sums, lower index wins ties
  logic              lo_sel;
  logic              hi_sel;
  logic              fin_sel;
  sum_t              lo_min;
  sum_t              hi_min;
  sum_t              best_dist;
  logic [NEAR_W-1:0] best_idx;

  always_comb begin
    lo_sel    = (s2_sum_r[1] < s2_sum_r[0]);
    hi_sel    = (s2_sum_r[3] < s2_sum_r[2]);
    lo_min    = lo_sel ? s2_sum_r[1] : s2_sum_r[0];
    hi_min    = hi_sel ? s2_sum_r[3] : s2_sum_r[2];
    fin_sel   = (hi_min < lo_min);
    best_dist = fin_sel ? hi_min : lo_min;
    best_idx  = fin_sel ? {1'b1, hi_sel} : {1'b0, lo_sel};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_near_r <= best_idx;
      out_dist_r <= best_dist;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_dist_r, out_near_r};

  // sums start from zero after a vector closes
  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_prod) |=>
      (sum_r[0] == '0) && (sum_r[1] == '0) && (sum_r[2] == '0) && (sum_r[3] == '0))
    else $error("distance sums not cleared after last beat");

  // input only stalls behind a blocked closed vector
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && s1_prod && s2_v_r && out_v_r && !out_tready))
    else $error("input stalled without a blocked result");

  // chosen distance is no larger than any final sum
  a_min_dist: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire |=> (out_dist_r <= $past(s2_sum_r[0])) && (out_dist_r <= $past(s2_sum_r[1]))
             && (out_dist_r <= $past(s2_sum_r[2])) && (out_dist_r <= $past(s2_sum_r[3])))
    else $error("reported distance is not the minimum");

endmodule

@@ test/nc_checker.sv @@
`timescale 1ns / 1ps

// watches both channels, predicts each closed vector's verdict and compares
module nc_checker
  import ncl1_pkg::*;
#(
  parameter int FEATURE_LEN = FEATURE_LEN_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // center_sel[1:0], elem_index[7:2], value[15:8]
  input  logic [0:0]  in_tuser,   // func[0]
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // nearest[1:0], best_distance[15:2]
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          ties_seen,
  output int          sat_seen
);

  localparam logic [ELEM_W-1:0] VAL_MASK = ELEM_W'((1 << VALUE_BITS) - 1);

  typedef struct packed {
    logic [NEAR_W-1:0] nearest;
    sum_t              distance;
  } verdict_t;

  // own image of the centre store and the running sums
  logic [ELEM_W-1:0] centre_img [NUM_CENTERS][FEATURE_LEN];
  sum_t              run_sum [NUM_CENTERS];
  verdict_t          verdict_q [$];

  int n_fail = 0;
  int n_res  = 0;
  int n_tie  = 0;
  int n_sat  = 0;

  assign fail_count   = n_fail;
  assign results_seen = n_res;
  assign ties_seen    = n_tie;
  assign sat_seen     = n_sat;

  // apply one accepted input beat to the image, queue a verdict on a closing beat
  task automatic take_beat(input logic [15:0] d, input logic f, input logic l);
    logic [SEL_W-1:0]  sel;
    logic [IDX_W-1:0]  idx;
    logic [ELEM_W-1:0] val;
    int unsigned       ctr_v;
    int unsigned       acc;
    int                c;
    int                best_c;
    sum_t              best_d;
    bit                tied;
    verdict_t          v;
    sel = d[1:0];
    idx = d[7:2];
    val = d[15:8] & VAL_MASK;
    if (f == FUNC_LOAD) begin
      // load beat: last mark has no effect
      if (idx < FEATURE_LEN) centre_img[sel][idx] = val;
    end else begin
      // absolute difference into every sum, saturating at the ceiling
      if (idx < FEATURE_LEN) begin
        for (c = 0; c < NUM_CENTERS; c++) begin
          ctr_v = centre_img[c][idx] & VAL_MASK;
          acc   = run_sum[c] + ((ctr_v > val) ? ctr_v - val : val - ctr_v);
          if (acc > SUM_MAX) acc = SUM_MAX;
          run_sum[c] = sum_t'(acc);
        end
      end
      if (l) begin
        // strict less-than keeps the lower index on a tie
        best_c = 0;
        best_d = run_sum[0];
        for (c = 1; c < NUM_CENTERS; c++) begin
          if (run_sum[c] < best_d) begin
            best_d = run_sum[c];
            best_c = c;
          end
        end
        tied = 1'b0;
        for (c = 0; c < NUM_CENTERS; c++) begin
          if (c != best_c && run_sum[c] == best_d) tied = 1'b1;
        end
        if (tied) n_tie++;
        if (best_d == SUM_MAX) n_sat++;
        v.nearest  = NEAR_W'(best_c);
        v.distance = best_d;
        verdict_q.push_back(v);
        for (c = 0; c < NUM_CENTERS; c++) run_sum[c] = '0;
      end
    end
  endtask

  // compare one result beat with the oldest queued verdict
  task automatic check_result(input logic [15:0] d);
    verdict_t exp_v;
    verdict_t got_v;
    got_v.nearest  = d[1:0];
    got_v.distance = d[15:2];
    n_res++;
    if (verdict_q.size() == 0) begin
      $error("result beat with no vector closed: nearest %0d best_distance %0d",
             got_v.nearest, got_v.distance);
      n_fail++;
    end else begin
      exp_v = verdict_q.pop_front();
      if (got_v.nearest !== exp_v.nearest) begin
        $error("nearest: expected %0d, got %0d", exp_v.nearest, got_v.nearest);
        n_fail++;
      end
      if (got_v.distance !== exp_v.distance) begin
        $error("best_distance: expected %0d, got %0d", exp_v.distance, got_v.distance);
        n_fail++;
      end
    end
  endtask

  // sample both channels on the edge that moves a beat
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CENTERS; c++) run_sum[c] = '0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) take_beat(in_tdata, in_tuser[0], in_tlast);
    end
    pending <= verdict_q.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ncl1_pkg::*;

  localparam int FEAT_LEN    = FEATURE_LEN_DEF;
  localparam int VAL_BITS    = VALUE_BITS_DEF;
  localparam int HOLD_CYCLES = 96;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_BEATS  = 1400;
  localparam int NUM_PHASES  = 6;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // center_sel[1:0], elem_index[7:2], value[15:8]
  logic [0:0]  in_tuser   = '0;   // func[0]
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // nearest[1:0], best_distance[15:2]

  int fail_count;
  int pending_cnt;
  int results_seen;
  int ties_seen;
  int sat_seen;

  int   beats_sent  = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_tgl    = 1'b0;
  int   idle_cycles = 0;

  nearest_center_l1_assign #(
    .FEATURE_LEN (FEAT_LEN),
    .VALUE_BITS  (VAL_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  nc_checker #(
    .FEATURE_LEN (FEAT_LEN),
    .VALUE_BITS  (VAL_BITS)
  ) chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending_cnt),
    .results_seen (results_seen),
    .ties_seen    (ties_seen),
    .sat_seen     (sat_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on each toggle request
  initial begin
    int   hold_left;
    logic seen_tgl;
    hold_left = 0;
    seen_tgl  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tgl != seen_tgl) begin
        seen_tgl  = hold_tgl;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // count cycles in which no beat moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // offer one beat after an optional random gap, return on its handshake edge
  task automatic send_beat(input logic f, input logic [SEL_W-1:0] sel,
                           input logic [IDX_W-1:0] idx, input logic [ELEM_W-1:0] val,
                           input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser[0] <= f;
    in_tdata    <= {val, idx, sel};
    in_tlast    <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // sender pause until every queued verdict has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // element value biased towards the extremes
  function automatic logic [ELEM_W-1:0] pick_value();
    int r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ELEM_W'($urandom_range(255));
  endfunction

  // one classified vector of a random flavour, with loads mixed in
  task automatic send_vector();
    int                kind;
    int                len;
    int                base;
    int                k;
    int                c;
    logic [ELEM_W-1:0] v;
    kind = $urandom_range(99);
    if (kind < 5) begin
      // extreme centres on a few elements, long mid-range vector: every sum saturates
      for (k = 0; k < 4; k++) begin
        for (c = 0; c < NUM_CENTERS; c++) begin
          send_beat(FUNC_LOAD, SEL_W'(c), IDX_W'(k), $urandom_range(1) ? '1 : '0, 1'b0);
        end
      end
      len = $urandom_range(140, 180);
      for (k = 0; k < len; k++) begin
        send_beat(FUNC_CLASSIFY, SEL_W'($urandom_range(3)), IDX_W'($urandom_range(3)),
                  ELEM_W'($urandom_range(120, 135)), k == len - 1);
      end
    end else if (kind < 20) begin
      // near-identical centres on a small window so that ties are frequent
      base = $urandom_range(FEAT_LEN - 4);
      for (k = 0; k < 4; k++) begin
        v = pick_value();
        for (c = 0; c < NUM_CENTERS; c++) begin
          send_beat(FUNC_LOAD, SEL_W'(c), IDX_W'(base + k),
                    ($urandom_range(2) == 0) ? v + 1'b1 : v, 1'($urandom_range(1)));
        end
      end
      len = $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
        send_beat(FUNC_CLASSIFY, SEL_W'($urandom_range(3)),
                  IDX_W'(base + $urandom_range(3)), pick_value(), k == len - 1);
      end
    end else begin
      // ordinary vector, now and then a long one, loads interleaved
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 90) : $urandom_range(1, 16);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(7) == 0) begin
          send_beat(FUNC_LOAD, SEL_W'($urandom_range(3)),
                    IDX_W'($urandom_range(FEAT_LEN - 1)), pick_value(),
                    1'($urandom_range(1)));
        end
        send_beat(FUNC_CLASSIFY, SEL_W'($urandom_range(3)),
                  IDX_W'($urandom_range(FEAT_LEN - 1)), pick_value(), k == len - 1);
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int c;
    int k;
    int p;
    int phase_end;
    logic [ELEM_W-1:0] v;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole store first so no unwritten entry is ever read;
    // centre 0 all zeros, centre 1 all ones, centre 2 a ramp, centre 3 random;
    // odd elements carry a last mark, which a load must ignore
    tx_idle_pct = 33;
    rx_idle_pct <= 33;
    for (c = 0; c < NUM_CENTERS; c++) begin
      for (k = 0; k < FEAT_LEN; k++) begin
        case (c)
          0:       v = '0;
          1:       v = '1;
          2:       v = ELEM_W'(k * 4);
          default: v = ELEM_W'($urandom_range(255));
        endcase
        send_beat(FUNC_LOAD, SEL_W'(c), IDX_W'(k), v, k[0]);
      end
    end

    // directed vectors: extremes, ties, load with last, back-to-back closes
    send_beat(FUNC_CLASSIFY, 2'b00, 6'd0, 8'h00, 1'b1);
    send_beat(FUNC_CLASSIFY, 2'b11, 6'd63, 8'hff, 1'b1);
    send_beat(FUNC_LOAD, 2'b11, 6'd5, 8'ha5, 1'b1);
    send_beat(FUNC_CLASSIFY, 2'b01, 6'd5, 8'ha5, 1'b1);
    send_beat(FUNC_CLASSIFY, 2'b10, 6'd10, 8'd40, 1'b0);
    send_beat(FUNC_CLASSIFY, 2'b01, 6'd11, 8'd44, 1'b1);
    send_beat(FUNC_CLASSIFY, 2'b00, 6'h2a, 8'h5a, 1'b0);
    send_beat(FUNC_CLASSIFY, 2'b11, 6'h15, 8'ha5, 1'b1);
    send_beat(FUNC_CLASSIFY, 2'b00, 6'd1, 8'd128, 1'b1);
    send_beat(FUNC_CLASSIFY, 2'b00, 6'd2, 8'd127, 1'b1);
    send_beat(FUNC_LOAD, 2'b00, 6'd7, 8'h00, 1'b1);
    send_beat(FUNC_CLASSIFY, 2'b10, 6'd7, 8'hff, 1'b0);
    send_beat(FUNC_CLASSIFY, 2'b10, 6'd7, 8'h00, 1'b0);
    send_beat(FUNC_CLASSIFY, 2'b01, 6'd62, 8'h80, 1'b1);
    wait_results_drained();

    // random phases with differing idle patterns, drained between phases
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin tx_idle_pct = 33; rx_idle_pct <= 33; end
        1: begin tx_idle_pct = 0;  rx_idle_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct <= 33; hold_tgl <= ~hold_tgl; end
        3: begin tx_idle_pct = 33; rx_idle_pct <= 0;  end
        4: begin tx_idle_pct = 0;  rx_idle_pct <= 33; end
        default: begin tx_idle_pct = 33; rx_idle_pct <= 33; hold_tgl <= ~hold_tgl; end
      endcase
      phase_end = beats_sent + RAND_BEATS / NUM_PHASES;
      while (beats_sent < phase_end) send_vector();
      wait_results_drained();
    end

    // let any stray result surface before the verdict
    repeat (20) @(posedge clk);

    $display("%0d input beats driven, %0d vectors classified and checked",
             beats_sent, results_seen);
    $display("%0d verdicts on a tie, %0d with a saturated best distance",
             ties_seen, sat_seen);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ nearest_center_l1_assign.f @@
design/ncl1_pkg.sv
design/ncl1_center_store.sv
design/nearest_center_l1_assign.sv
test/nc_checker.sv
test/tb_top.sv
